// File: design/connection_table_wildcard_lookup_defines.svh
// Assertion helpers for the connection table lookup.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef CONNECTION_TABLE_WILDCARD_LOOKUP_DEFINES_SVH
`define CONNECTION_TABLE_WILDCARD_LOOKUP_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define CTWL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CTWL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ctwl_pkg.sv
`timescale 1ns / 1ps

package ctwl_pkg;

    // Fixed field widths
    localparam int SLOT_W  = 5;
    localparam int PORT_W  = 16;
    localparam int ADDR_W  = 32;
    localparam int SCORE_W = 3;

    // Score that marks a rejected slot; never chosen
    localparam logic [SCORE_W-1:0] NO_MATCH_SCORE = 3'd5;

    // Reset value of the network mask
    localparam logic [ADDR_W-1:0] NET_MASK_RESET = 32'hFFFF_FF00;

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Fields stored in one slot
    typedef struct packed {
        logic [PORT_W-1:0] local_port;
        logic [ADDR_W-1:0] local_addr;
        logic [ADDR_W-1:0] foreign_addr;
        logic [PORT_W-1:0] foreign_port;
    } entry_t;

    // Lookup query, held for the whole scan
    typedef struct packed {
        logic [PORT_W-1:0] local_port;
        logic [ADDR_W-1:0] local_addr;
        logic [ADDR_W-1:0] net_part;
        logic [ADDR_W-1:0] foreign_addr;
        logic [PORT_W-1:0] foreign_port;
    } query_t;

    // Running best match, handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               stop;
        logic               hit;
        logic [SCORE_W-1:0] score;
        logic [SLOT_W-1:0]  slot;
    } token_t;

endpackage

// File: design/connection_table_wildcard_lookup.sv
// Write: result strobe (done) in the cycle after start is taken; one write per cycle
//   while not busy. Lookup: a token walks a row of ENTRIES cells, one cell per cycle;
//   start goes through launch_reg, the ENTRIES cell registers and the done register,
//   busy is high until done, so no new lookup is taken before the last is done.
// Results are never stalled. Reset clears all slots to not eligible, net_mask to
//   0xFFFFFF00 and all control state.
`timescale 1ns / 1ps
`include "connection_table_wildcard_lookup_defines.svh"

module connection_table_wildcard_lookup
    import ctwl_pkg::*;
#(
    parameter int ENTRIES = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              op,
    input  logic [SLOT_W-1:0] slot,
    input  logic              slot_eligible,
    input  logic [PORT_W-1:0] local_port,
    input  logic [ADDR_W-1:0] local_addr,
    input  logic [ADDR_W-1:0] foreign_addr,
    input  logic [PORT_W-1:0] foreign_port,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data,
    output logic              done,
    output logic              found,
    output logic [SLOT_W-1:0] match_slot,
    output logic [SCORE_W-1:0] wildcards
);

    logic               busy_reg;
    logic               launch_reg;
    logic [ADDR_W-1:0]  net_mask_reg;
    query_t             query_reg;
    logic               done_reg;
    logic               found_reg;
    logic [SLOT_W-1:0]  match_slot_reg;
    logic [SCORE_W-1:0] wildcards_reg;

    logic   accept;
    logic   wr_acc;
    logic   lookup_acc;
    entry_t wr_entry;
    token_t tok [ENTRIES+1];
    token_t tail;

    assign accept     = start && !busy_reg;
    assign wr_acc     = accept && (op == OP_WRITE);
    assign lookup_acc = accept && (op == OP_LOOKUP);

    assign wr_entry.local_port   = local_port;
    assign wr_entry.local_addr   = local_addr;
    assign wr_entry.foreign_addr = foreign_addr;
    assign wr_entry.foreign_port = foreign_port;

    // Seed token entering the first cell
    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = launch_reg;
        tok[0].score  = NO_MATCH_SCORE;
    end

    // Row of slot cells
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic wr_sel;
        assign wr_sel = wr_acc && (32'(slot) == 32'(g));

        ctwl_cell #(
            .IDX (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr_en       (wr_sel),
            .wr_eligible (slot_eligible),
            .wr_entry    (wr_entry),
            .query       (query_reg),
            .tok_in      (tok[g]),
            .tok_out     (tok[g+1])
        );
    end

    assign tail = tok[ENTRIES];

    // Capture the query at accept
    always_ff @(posedge clk)
    begin
        if (lookup_acc)
        begin
            query_reg.local_port   <= local_port;
            query_reg.local_addr   <= local_addr;
            query_reg.net_part     <= local_addr & net_mask_reg;
            query_reg.foreign_addr <= foreign_addr;
            query_reg.foreign_port <= foreign_port;
        end
    end

    // Control, configuration and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            launch_reg     <= 1'b0;
            net_mask_reg   <= NET_MASK_RESET;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            match_slot_reg <= '0;
            wildcards_reg  <= '0;
        end
        else
        begin
            launch_reg <= lookup_acc;
            if (cfg_valid && cfg_ready)
                net_mask_reg <= cfg_data;

            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            match_slot_reg <= '0;
            wildcards_reg  <= '0;

            if (lookup_acc)
                busy_reg <= 1'b1;
            else if (tail.active)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                if (tail.hit)
                begin
                    found_reg      <= 1'b1;
                    match_slot_reg <= tail.slot;
                    wildcards_reg  <= tail.score;
                end
            end

            if (wr_acc)
                done_reg <= 1'b1;
        end
    end

    assign busy       = busy_reg;
    assign cfg_ready  = !busy_reg;
    assign done       = done_reg;
    assign found      = found_reg;
    assign match_slot = match_slot_reg;
    assign wildcards  = wildcards_reg;

    // Checks
    `CTWL_ASSERT_SAME(a_score_range, done && found, wildcards <= 3'd4, "score above four reported")
    `CTWL_ASSERT_SAME(a_miss_zero, done && !found, match_slot == '0 && wildcards == '0, "miss not zero")
    `CTWL_ASSERT_NEXT(a_write_beat, wr_acc, done && !found && !busy, "write result missing")
    `CTWL_ASSERT_SAME(a_busy_end, $fell(busy_reg), done_reg, "scan ended without result")
    `CTWL_ASSERT_SAME(a_one_token, busy_reg && tail.active, !launch_reg, "token overlap in row")

endmodule

// File: design/ctwl_cell.sv
`timescale 1ns / 1ps

module ctwl_cell
    import ctwl_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  logic   wr_eligible,
    input  entry_t wr_entry,
    input  query_t query,
    input  token_t tok_in,
    output token_t tok_out
);

    localparam logic [SLOT_W-1:0] TAG = SLOT_W'(IDX);

    logic   valid_reg;
    entry_t entry_reg;
    token_t tok_reg;
    token_t tok_next;
    logic [SCORE_W-1:0] score;

    // Score this slot against the query; rejected slots get NO_MATCH_SCORE
    function automatic logic [SCORE_W-1:0] calc_score(entry_t e, query_t q);
        logic [SCORE_W-1:0] w;
        logic               rej;
        w   = '0;
        rej = 1'b0;
        if (e.local_port != '0)
        begin
            if (e.local_port != q.local_port)
                rej = 1'b1;
        end
        else
            w = w + 3'd1;

        if (e.local_addr == q.net_part)
            w = w + 3'd1;
        else if (e.local_addr != '0)
        begin
            if (q.local_addr == '0)
                w = w + 3'd2;
            else if (e.local_addr != q.local_addr)
                rej = 1'b1;
        end
        else if (q.local_addr != '0)
            w = w + 3'd2;

        if (e.foreign_addr != '0)
        begin
            if (q.foreign_addr == '0)
                w = w + 3'd2;
            else if (e.foreign_addr != q.foreign_addr ||
                     e.foreign_port != q.foreign_port)
                rej = 1'b1;
        end
        else if (q.foreign_addr != '0)
            w = w + 3'd2;

        return rej ? NO_MATCH_SCORE : w;
    endfunction

    assign score = calc_score(entry_reg, query);

    // Take over the running best when this slot scores lower
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.stop && valid_reg && score < tok_in.score)
        begin
            tok_next.score = score;
            tok_next.slot  = TAG;
            tok_next.hit   = 1'b1;
            tok_next.stop  = (score == '0);
        end
    end

    // Hold the eligible bit and pass the token on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            if (wr_en)
                valid_reg <= wr_eligible;
            tok_reg <= tok_next;
        end
    end

    // Slot fields, undefined until written
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg <= wr_entry;
    end

    assign tok_out = tok_reg;

endmodule
